// ----- sv/gbd_pkg.sv -----
package gbd_pkg;

  localparam int SampleW      = 12;
  localparam int StateW       = 36;
  localparam int CoefW        = 18;
  localparam int CoefFracBits = 16;
  localparam int LenW         = 9;
  localparam int MaxBlock     = 256;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 18;

  localparam int MulAW     = StateW + 1;
  localparam int MulBW     = CoefW + 1;
  localparam int ProdW     = MulAW + MulBW;
  localparam int WideW     = 58;
  localparam int SqChunkW  = StateW / 2;
  localparam int SqProdW   = StateW + SqChunkW;
  localparam int AccW      = 2 * StateW;
  localparam int RemW      = StateW + 3;
  localparam int RootIterW = 6;
  localparam int StepW     = 4;

  localparam logic [CfgIdxW-1:0] REG_BLOCK_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_BIN_COSINE   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BIN_SINE     = 2'd2;

  typedef logic [StepW-1:0] step_t;

  localparam step_t STEP_IDLE = 4'd0;
  localparam step_t STEP_UPD  = 4'd1;
  localparam step_t STEP_END0 = 4'd2;
  localparam step_t STEP_END1 = 4'd3;
  localparam step_t STEP_END2 = 4'd4;
  localparam step_t STEP_SQ0  = 4'd5;
  localparam step_t STEP_SQ1  = 4'd6;
  localparam step_t STEP_SQ2  = 4'd7;
  localparam step_t STEP_SQ3  = 4'd8;
  localparam step_t STEP_ROOT = 4'd9;
  localparam step_t STEP_EMIT = 4'd10;

  typedef enum logic [2:0] {
    MUL_Q1_COS,
    MUL_Q2_COS,
    MUL_Q2_SIN,
    MUL_RE_LO,
    MUL_RE_HI,
    MUL_IM_LO,
    MUL_IM_HI
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_BLOCK_OPEN,
    COND_ROOT_BUSY,
    COND_OUT_FULL
  } cond_e;

  typedef struct packed {
    logic     in_en;
    mul_sel_e mul_sel;
    logic     q_upd;
    logic     re_ld;
    logic     im_ld;
    acc_op_e  acc_op;
    logic     st_clr;
    logic     root_init;
    logic     root_step;
    logic     emit;
    cond_e    cond;
    step_t    next_hit;
    step_t    next_miss;
  } ctrl_t;

  typedef struct packed {
    logic in_fire;
    logic block_open;
    logic root_busy;
    logic out_full;
  } status_t;

  function automatic logic signed [StateW-1:0] sat_state(input logic signed [WideW-1:0] x);
    if (x[WideW-1:StateW-1] == {(WideW-StateW+1){x[WideW-1]}}) begin
      return x[StateW-1:0];
    end
    return x[WideW-1] ? {1'b1, {(StateW-1){1'b0}}} : {1'b0, {(StateW-1){1'b1}}};
  endfunction

  // microprogram: one control word per step
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t c;
    c           = '0;
    c.cond      = COND_ALWAYS;
    c.next_hit  = STEP_IDLE;
    c.next_miss = STEP_IDLE;
    case (s)
      STEP_IDLE: begin
        c.in_en     = 1'b1;
        c.mul_sel   = MUL_Q1_COS;
        c.cond      = COND_NO_INPUT;
        c.next_hit  = STEP_IDLE;
        c.next_miss = STEP_UPD;
      end
      STEP_UPD: begin
        c.q_upd     = 1'b1;
        c.cond      = COND_BLOCK_OPEN;
        c.next_hit  = STEP_IDLE;
        c.next_miss = STEP_END0;
      end
      STEP_END0: begin
        c.mul_sel  = MUL_Q2_COS;
        c.next_hit = STEP_END1;
      end
      STEP_END1: begin
        c.re_ld    = 1'b1;
        c.mul_sel  = MUL_Q2_SIN;
        c.next_hit = STEP_END2;
      end
      STEP_END2: begin
        c.im_ld    = 1'b1;
        c.mul_sel  = MUL_RE_LO;
        c.next_hit = STEP_SQ0;
      end
      STEP_SQ0: begin
        c.acc_op   = ACC_LOAD;
        c.mul_sel  = MUL_RE_HI;
        c.next_hit = STEP_SQ1;
      end
      STEP_SQ1: begin
        c.acc_op   = ACC_ADD_HI;
        c.mul_sel  = MUL_IM_LO;
        c.next_hit = STEP_SQ2;
      end
      STEP_SQ2: begin
        c.acc_op   = ACC_ADD;
        c.mul_sel  = MUL_IM_HI;
        c.next_hit = STEP_SQ3;
      end
      STEP_SQ3: begin
        c.acc_op    = ACC_ADD_HI;
        c.st_clr    = 1'b1;
        c.root_init = 1'b1;
        c.next_hit  = STEP_ROOT;
      end
      STEP_ROOT: begin
        c.root_step = 1'b1;
        c.cond      = COND_ROOT_BUSY;
        c.next_hit  = STEP_ROOT;
        c.next_miss = STEP_EMIT;
      end
      STEP_EMIT: begin
        c.emit      = 1'b1;
        c.cond      = COND_OUT_FULL;
        c.next_hit  = STEP_EMIT;
        c.next_miss = STEP_IDLE;
      end
      default: begin
        c.next_hit = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- sv/gbd_if.sv -----
interface gbd_in_if;
  import gbd_pkg::*;
  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface gbd_out_if;
  import gbd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [StateW-1:0] real_part;
  logic signed [StateW-1:0] imag_part;
  logic [StateW-1:0]        magnitude;
  modport source (output valid, output real_part, output imag_part, output magnitude,
                  input ready);
  modport sink (input valid, input real_part, input imag_part, input magnitude,
                output ready);
endinterface

// ----- sv/gbd_seq.sv -----
module gbd_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbd_pkg::status_t status_i,
  output gbd_pkg::ctrl_t   ctrl_o,
  output gbd_pkg::step_t   step_o
);
  import gbd_pkg::*;

  step_t step_q, step_d;
  logic  hit;

  assign ctrl_o = ucode(step_q);
  assign step_o = step_q;

  always_comb begin
    case (ctrl_o.cond)
      COND_ALWAYS:     hit = 1'b1;
      COND_NO_INPUT:   hit = ~status_i.in_fire;
      COND_BLOCK_OPEN: hit = status_i.block_open;
      COND_ROOT_BUSY:  hit = status_i.root_busy;
      COND_OUT_FULL:   hit = status_i.out_full;
      default:         hit = 1'b1;
    endcase
    step_d = hit ? ctrl_o.next_hit : ctrl_o.next_miss;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ----- sv/gbd_dp.sv -----
module gbd_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gbd_pkg::ctrl_t                    ctrl_i,
  input  logic                              in_fire_i,
  input  logic [gbd_pkg::SampleW-1:0]       sample_i,
  input  logic [gbd_pkg::LenW-1:0]          block_length_i,
  input  logic signed [gbd_pkg::CoefW-1:0]  bin_cosine_i,
  input  logic signed [gbd_pkg::CoefW-1:0]  bin_sine_i,
  input  logic                              out_ready_i,
  output gbd_pkg::status_t                  status_o,
  output logic                              out_valid_o,
  output logic signed [gbd_pkg::StateW-1:0] real_part_o,
  output logic signed [gbd_pkg::StateW-1:0] imag_part_o,
  output logic [gbd_pkg::StateW-1:0]        magnitude_o
);
  import gbd_pkg::*;

  logic [SampleW-1:0]       x_q;
  logic [LenW-1:0]          count_q;
  logic signed [StateW-1:0] q1_q, q2_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [StateW-1:0] re_q, im_q;
  logic [AccW-1:0]          acc_q;
  logic [RemW-1:0]          rem_q;
  logic [StateW-1:0]        root_q;
  logic [RootIterW-1:0]     iter_q;
  logic                     out_valid_q;
  logic signed [StateW-1:0] real_q, imag_q;
  logic [StateW-1:0]        mag_q;

  logic [LenW-1:0]          len_eff;
  logic [StateW-1:0]        re_abs, im_abs;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW:0]    prod_dbl;
  logic signed [WideW-1:0]  q0_wide, re_wide, im_wide;
  logic [AccW-1:0]          sq_term;
  logic [RemW-1:0]          rem_try, trial;
  logic                     root_ge;
  logic                     emit_load;

  always_comb begin
    if (block_length_i == '0) begin
      len_eff = LenW'(1);
    end else if (block_length_i > LenW'(MaxBlock)) begin
      len_eff = LenW'(MaxBlock);
    end else begin
      len_eff = block_length_i;
    end
  end

  assign re_abs = re_q[StateW-1] ? -re_q : re_q;
  assign im_abs = im_q[StateW-1] ? -im_q : im_q;

  // shared multiplier: recursion, block-end terms and partial squares
  always_comb begin
    case (ctrl_i.mul_sel)
      MUL_Q1_COS: begin
        mul_a = {q1_q[StateW-1], q1_q};
        mul_b = {bin_cosine_i[CoefW-1], bin_cosine_i};
      end
      MUL_Q2_COS: begin
        mul_a = {q2_q[StateW-1], q2_q};
        mul_b = {bin_cosine_i[CoefW-1], bin_cosine_i};
      end
      MUL_Q2_SIN: begin
        mul_a = {q2_q[StateW-1], q2_q};
        mul_b = {bin_sine_i[CoefW-1], bin_sine_i};
      end
      MUL_RE_LO: begin
        mul_a = {1'b0, re_abs};
        mul_b = {1'b0, re_abs[SqChunkW-1:0]};
      end
      MUL_RE_HI: begin
        mul_a = {1'b0, re_abs};
        mul_b = {1'b0, re_abs[StateW-1:SqChunkW]};
      end
      MUL_IM_LO: begin
        mul_a = {1'b0, im_abs};
        mul_b = {1'b0, im_abs[SqChunkW-1:0]};
      end
      MUL_IM_HI: begin
        mul_a = {1'b0, im_abs};
        mul_b = {1'b0, im_abs[StateW-1:SqChunkW]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_dbl = {prod_q, 1'b0};
  assign q0_wide  = WideW'(prod_dbl >>> CoefFracBits) - WideW'(q2_q)
                  + WideW'(signed'({1'b0, x_q}));
  assign re_wide  = WideW'(q1_q) - WideW'(prod_q >>> CoefFracBits);
  assign im_wide  = WideW'(prod_q >>> CoefFracBits);
  assign sq_term  = AccW'(prod_q[SqProdW-1:0]);

  // restoring square root, one result bit per step
  assign rem_try = {rem_q[RemW-3:0], acc_q[AccW-1 -: 2]};
  assign trial   = RemW'({root_q, 2'b01});
  assign root_ge = rem_try >= trial;

  assign emit_load = ctrl_i.emit & ~out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      q1_q        <= '0;
      q2_q        <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.st_clr) begin
        count_q <= '0;
      end else if (in_fire_i) begin
        count_q <= count_q + 1'b1;
      end
      if (ctrl_i.st_clr) begin
        q1_q <= '0;
        q2_q <= '0;
      end else if (ctrl_i.q_upd) begin
        q2_q <= q1_q;
        q1_q <= sat_state(q0_wide);
      end
      if (ctrl_i.root_init) begin
        iter_q <= RootIterW'(StateW - 1);
      end else if (ctrl_i.root_step && iter_q != '0) begin
        iter_q <= iter_q - 1'b1;
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    if (in_fire_i) begin
      x_q <= sample_i;
    end
    if (ctrl_i.re_ld) begin
      re_q <= sat_state(re_wide);
    end
    if (ctrl_i.im_ld) begin
      im_q <= sat_state(im_wide);
    end
    case (ctrl_i.acc_op)
      ACC_LOAD:   acc_q <= sq_term;
      ACC_ADD:    acc_q <= acc_q + sq_term;
      ACC_ADD_HI: acc_q <= acc_q + (sq_term << SqChunkW);
      default: begin
        if (ctrl_i.root_step) begin
          acc_q <= acc_q << 2;
        end
      end
    endcase
    if (ctrl_i.root_init) begin
      rem_q  <= '0;
      root_q <= '0;
    end else if (ctrl_i.root_step) begin
      rem_q  <= root_ge ? rem_try - trial : rem_try;
      root_q <= {root_q[StateW-2:0], root_ge};
    end
    if (emit_load) begin
      real_q <= re_q;
      imag_q <= im_q;
      mag_q  <= root_q;
    end
  end

  assign status_o.in_fire    = in_fire_i;
  assign status_o.block_open = count_q < len_eff;
  assign status_o.root_busy  = iter_q != '0;
  assign status_o.out_full   = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign real_part_o = real_q;
  assign imag_part_o = imag_q;
  assign magnitude_o = mag_q;

endmodule

// ----- sv/goertzel_single_bin_detector.sv -----
// Each sample: accepted in the idle step, recursion updated in the next step; no new sample
// is accepted during the update. Block end runs 7 steps on the shared multiplier (real,
// imaginary, partial squares), 36 square-root steps at one bit per cycle, then the output
// register load.
// Samples of the next block are taken while a result waits in the output register.
// rst_ni is asynchronous: state cleared, length 80, cosine 1.0, sine 0.
module goertzel_single_bin_detector (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [gbd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [gbd_pkg::CfgDataW-1:0]    cfg_data_i,
  gbd_in_if.sink                          in_i,
  gbd_out_if.source                       out_o
);
  import gbd_pkg::*;

  logic [LenW-1:0]         block_length_q;
  logic signed [CoefW-1:0] bin_cosine_q, bin_sine_q;
  ctrl_t                   ctrl;
  status_t                 status;
  step_t                   step;
  logic                    in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q <= LenW'(80);
      bin_cosine_q   <= CoefW'(1 << CoefFracBits);
      bin_sine_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLOCK_LENGTH: block_length_q <= cfg_data_i[LenW-1:0];
        REG_BIN_COSINE:   bin_cosine_q   <= cfg_data_i[CoefW-1:0];
        REG_BIN_SINE:     bin_sine_q     <= cfg_data_i[CoefW-1:0];
        default: ;
      endcase
    end
  end

  assign in_i.ready = ctrl.in_en;
  assign in_fire    = in_i.valid & ctrl.in_en;

  gbd_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .step_o   (step)
  );

  gbd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .in_fire_i      (in_fire),
    .sample_i       (in_i.sample),
    .block_length_i (block_length_q),
    .bin_cosine_i   (bin_cosine_q),
    .bin_sine_i     (bin_sine_q),
    .out_ready_i    (out_o.ready),
    .status_o       (status),
    .out_valid_o    (out_o.valid),
    .real_part_o    (out_o.real_part),
    .imag_part_o    (out_o.imag_part),
    .magnitude_o    (out_o.magnitude)
  );

  a_fire_to_upd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (step == STEP_UPD))
    else $error("sample transfer not followed by recursion update");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> ($past(step) == STEP_EMIT))
    else $error("result raised outside the emit step");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step == STEP_IDLE && $past(step) == STEP_EMIT) |-> out_o.valid)
    else $error("emit step left without loading a result");

endmodule

// ----- sim/goertzel_bin_checker.sv -----
`timescale 1ns / 1ps
module goertzel_bin_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gbd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [gbd_pkg::CfgDataW-1:0] cfg_data_i,
  gbd_in_if                            smp_i,
  gbd_out_if                           res_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           blocks_o
);
  import gbd_pkg::*;

  localparam longint StateMax = 64'sd34359738367;
  localparam longint StateMin = -64'sd34359738368;

  typedef struct packed {
    logic signed [StateW-1:0] re;
    logic signed [StateW-1:0] im;
    logic [StateW-1:0]        mag;
  } bin_result_t;

  bin_result_t bins_due[$];

  // shadow of the detector: coefficients, block length, recursion state
  logic [LenW-1:0]          blk_len;
  logic signed [CoefW-1:0]  cos_c;
  logic signed [CoefW-1:0]  sin_c;
  logic signed [StateW-1:0] q1;
  logic signed [StateW-1:0] q2;
  int unsigned              taken;

  function automatic logic signed [StateW-1:0] clamp36(input longint v);
    if (v > StateMax) return StateMax[StateW-1:0];
    if (v < StateMin) return StateMin[StateW-1:0];
    return v[StateW-1:0];
  endfunction

  // floor square root of re^2 + im^2, one result bit per trial
  function automatic logic [StateW-1:0] bin_magnitude(input logic signed [StateW-1:0] re,
                                                      input logic signed [StateW-1:0] im);
    longint            a_re;
    longint            a_im;
    logic [71:0]       energy;
    logic [71:0]       trial_sq;
    logic [StateW-1:0] root;
    logic [StateW-1:0] trial;
    a_re = re;
    a_im = im;
    if (a_re < 0) a_re = -a_re;
    if (a_im < 0) a_im = -a_im;
    energy = 72'(a_re) * 72'(a_re) + 72'(a_im) * 72'(a_im);
    root = '0;
    for (int b = StateW - 1; b >= 0; b--) begin
      trial = root | (36'd1 << b);
      trial_sq = 72'(trial) * 72'(trial);
      if (trial_sq <= energy) root = trial;
    end
    return root;
  endfunction

  // one recursion step; returns 1 when the sample closes a block
  function automatic logic goertzel_feed(input logic [SampleW-1:0] smp, output bin_result_t res);
    longint      x;
    longint      q0;
    longint      re_w;
    longint      im_w;
    int unsigned n;
    res = '0;
    n = blk_len;
    if (n == 0) n = 1;
    if (n > MaxBlock) n = MaxBlock;
    x = smp;
    q0 = ((2 * longint'(cos_c) * longint'(q1)) >>> CoefFracBits) - longint'(q2) + x;
    q2 = q1;
    q1 = clamp36(q0);
    taken++;
    if (taken < n) return 1'b0;
    re_w = longint'(q1) - ((longint'(q2) * longint'(cos_c)) >>> CoefFracBits);
    im_w = (longint'(q2) * longint'(sin_c)) >>> CoefFracBits;
    res.re = clamp36(re_w);
    res.im = clamp36(im_w);
    res.mag = bin_magnitude(res.re, res.im);
    q1 = '0;
    q2 = '0;
    taken = 0;
    return 1'b1;
  endfunction

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
               $time, what, want, want[StateW-1:0], got, got[StateW-1:0]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bin_result_t got;
    bin_result_t want;
    bin_result_t fresh;
    if (!rst_ni) begin
      blk_len = 9'd80;
      cos_c = 18'sd65536;
      sin_c = '0;
      q1 = '0;
      q2 = '0;
      taken = 0;
      bins_due.delete();
      fail_count_o = 0;
      pending_o = 0;
      blocks_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BLOCK_LENGTH: blk_len = cfg_data_i[LenW-1:0];
          REG_BIN_COSINE:   cos_c = cfg_data_i;
          REG_BIN_SINE:     sin_c = cfg_data_i;
          default: ;
        endcase
      end
      // results first: a sample taken at this edge cannot have its result out yet
      if (res_i.valid && res_i.ready) begin
        got.re = res_i.real_part;
        got.im = res_i.imag_part;
        got.mag = res_i.magnitude;
        if (bins_due.size() == 0) begin
          fail_count_o++;
          $display("%0t: result transfer with nothing expected, got re %0d im %0d mag %0d",
                   $time, got.re, got.im, got.mag);
        end else begin
          want = bins_due.pop_front();
          check_field("real_part", want.re, got.re);
          check_field("imag_part", want.im, got.im);
          check_field("magnitude", longint'(want.mag), longint'(got.mag));
          blocks_o++;
        end
      end
      if (smp_i.valid && smp_i.ready) begin
        if (goertzel_feed(smp_i.sample, fresh)) bins_due.push_back(fresh);
      end
      pending_o = bins_due.size();
    end
  end

endmodule

// ----- sim/goertzel_single_bin_detector_tb.sv -----
`timescale 1ns / 1ps
module goertzel_single_bin_detector_tb;
  import gbd_pkg::*;

  localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;  // no register behind it

  localparam int RandomItems  = 1800;
  localparam int SettleCycles = 60;   // lets the block end finish after the last sample
  localparam int LongHold     = 400;
  localparam int QuietLimit   = 5000;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_mode_e;
  typedef enum {SMP_RANDOM, SMP_EXTREME, SMP_SMALL, SMP_FULL_SCALE} smp_mode_e;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int        fail_count;
  int        pending;
  int        blocks;
  int        hold_req = 0;
  int        hold_ack = 0;
  int        samples_sent = 0;
  int        setups = 0;
  int        quiet = 0;
  int        gap_max = 0;
  int        burst_max = 1;
  smp_mode_e smp_mode = SMP_RANDOM;

  gbd_in_if  smp_ch ();
  gbd_out_if res_ch ();

  goertzel_single_bin_detector dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (smp_ch),
    .out_o      (res_ch)
  );

  goertzel_bin_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .smp_i        (smp_ch),
    .res_i        (res_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .blocks_o     (blocks)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QuietLimit) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet, pending);
      $display("FAILURE");
      $finish;
    end
  end

  // result side: changing stall pattern, plus long hold-offs on request
  initial begin : receiver
    rx_mode_e mode;
    int       span;
    int       period;
    int       low_len;
    int       pos;
    res_ch.ready = 1'b0;
    mode = RX_OPEN;
    span = 0;
    period = 2;
    low_len = 1;
    pos = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        res_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
      end
      if (span == 0) begin
        mode = rx_mode_e'($urandom_range(0, 2));
        span = $urandom_range(50, 300);
        period = $urandom_range(2, 9);
        low_len = $urandom_range(1, period - 1);
        pos = 0;
      end
      span--;
      case (mode)
        RX_OPEN:   res_ch.ready <= 1'b1;
        RX_RANDOM: res_ch.ready <= ($urandom_range(0, 99) < 60);
        default: begin
          res_ch.ready <= (pos >= low_len);
          pos = (pos + 1) % period;
        end
      endcase
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_data <= CfgDataW'($urandom);
  endtask

  // upper data bits are don't-care for the length register
  task automatic set_length(input int len);
    write_reg(REG_BLOCK_LENGTH, {9'($urandom), 9'(len)});
  endtask

  task automatic push_sample(input logic [SampleW-1:0] v);
    @(negedge clk);
    smp_ch.valid <= 1'b1;
    smp_ch.sample <= v;
    do @(posedge clk); while (!smp_ch.ready);
    samples_sent++;
  endtask

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      smp_ch.valid <= 1'b0;
      smp_ch.sample <= SampleW'($urandom);
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  // pause the sender until every result is in, then let a partial block finish its update
  task automatic drain_and_settle();
    idle_sender(1);
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  function automatic logic [SampleW-1:0] next_sample();
    case (smp_mode)
      SMP_EXTREME:    return $urandom_range(0, 1) ? '1 : '0;
      SMP_SMALL:      return SampleW'($urandom_range(0, 15));
      SMP_FULL_SCALE: return '1;
      default:        return SampleW'($urandom);
    endcase
  endfunction

  task automatic play_samples(input int count);
    int burst;
    burst = $urandom_range(1, burst_max);
    for (int i = 0; i < count; i++) begin
      if (burst == 0) begin
        idle_sender($urandom_range(0, gap_max));
        burst = $urandom_range(1, burst_max);
      end
      push_sample(next_sample());
      burst--;
    end
  endtask

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(1, 8);
    if (r < 80) return $urandom_range(9, 40);
    if (r < 92) return $urandom_range(41, 128);
    if (r < 95) return 0;
    if (r < 97) return MaxBlock;
    return $urandom_range(MaxBlock + 1, 511);
  endfunction

  function automatic logic [CfgDataW-1:0] pick_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return CfgDataW'($urandom_range(0, 131072) - 65536);
    if (r < 85) begin
      case ($urandom_range(0, 4))
        0:       return 18'h20000;  // -2.0
        1:       return 18'h1FFFF;  // just under +2.0
        2:       return 18'h10000;  // +1.0
        3:       return 18'h30000;  // -1.0
        default: return '0;
      endcase
    end
    return CfgDataW'($urandom);
  endfunction

  initial begin : stimulus
    int len_raw;
    int eff;
    int count;
    int base;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_BLOCK_LENGTH;
    cfg_data = '0;
    smp_ch.valid = 1'b0;
    smp_ch.sample = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one sample per block at cosine 1.0, sine 0
    set_length(1);
    push_sample('0);
    push_sample('1);
    push_sample(12'hA5A);
    drain_and_settle();

    // zero length behaves as one
    set_length(0);
    push_sample(12'h5A5);
    push_sample('1);
    drain_and_settle();

    // length lowered below the count of an open block: next sample closes it
    set_length(8);
    write_reg(REG_BIN_COSINE, 18'd46341);
    write_reg(REG_BIN_SINE, 18'd46341);
    repeat (5) push_sample(SampleW'($urandom));
    drain_and_settle();
    set_length(3);
    push_sample(SampleW'($urandom));
    drain_and_settle();

    // coefficients at -2.0 blow up the state: saturation everywhere
    write_reg(REG_BIN_COSINE, 18'h20000);
    write_reg(REG_BIN_SINE, 18'h20000);
    write_reg(REG_SPARE, CfgDataW'($urandom));
    set_length(16);
    repeat (16) push_sample('1);
    drain_and_settle();
    setups = 4;

    base = samples_sent;
    while (samples_sent - base < RandomItems) begin
      setups++;
      len_raw = pick_length();
      if (setups == 5) len_raw = $urandom_range(MaxBlock + 1, 511);
      if (setups % 12 == 7) len_raw = $urandom_range(1, 2);
      eff = (len_raw == 0) ? 1 : ((len_raw > MaxBlock) ? MaxBlock : len_raw);
      set_length(len_raw);
      write_reg(REG_BIN_COSINE, pick_coef());
      write_reg(REG_BIN_SINE, pick_coef());
      if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, CfgDataW'($urandom));

      smp_mode = smp_mode_e'($urandom_range(0, 99) < 70 ? 0 : $urandom_range(1, 3));
      if ($urandom_range(0, 3) == 0) begin
        gap_max = 0;
        burst_max = 64;
      end else begin
        gap_max = $urandom_range(1, 12);
        burst_max = $urandom_range(1, 16);
      end

      if (eff >= 128) begin
        count = eff;
      end else if (eff <= 4) begin
        count = eff * $urandom_range(1, 8);
      end else begin
        count = eff * $urandom_range(1, 3);
      end
      if ($urandom_range(0, 2) == 0) count += $urandom_range(0, eff - 1);

      // hold results back while samples keep coming, so the input stalls
      if (setups % 12 == 7) begin
        gap_max = 0;
        burst_max = 64;
        count = 12;
        hold_req++;
      end

      play_samples(count);
      drain_and_settle();
    end

    $display("Covered %0d samples over %0d setups with %0d blocks compared,", samples_sent,
             setups, blocks);
    $display("lengths from zero to past the maximum, coefficients to both limits, long stalls.");
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/gbd_pkg.sv
sv/gbd_if.sv
sv/gbd_seq.sv
sv/gbd_dp.sv
sv/goertzel_single_bin_detector.sv
sim/goertzel_bin_checker.sv
sim/goertzel_single_bin_detector_tb.sv
